// ----- rtl/tmed_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tmed_pkg;

  localparam int unsigned MAX_FRAMES  = 8;
  localparam int unsigned LANES       = 8;
  localparam int unsigned SAMPLE_W    = 8;
  localparam int unsigned COUNT_W     = 4;
  localparam int unsigned BOUND_RAW   = (MAX_FRAMES < LANES) ? MAX_FRAMES : LANES;
  localparam int unsigned BOUND       = (BOUND_RAW < 1) ? 1 : BOUND_RAW;
  localparam int unsigned TDATA_IN_W  = LANES * SAMPLE_W;
  localparam int unsigned TDATA_OUT_W = SAMPLE_W;
  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(8);

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [COUNT_W-1:0]  count_t;

  // One pixel position with the number of frames that take part.
  typedef struct packed {
    sample_t [LANES-1:0] samples;
    count_t              n;
  } median_req_t;

  // Zero counts as one, anything above the lane bound saturates.
  function automatic count_t effective_count(input count_t raw);
    count_t n;
    n = raw;
    if (n == '0) begin
      n = COUNT_W'(1);
    end
    if (n > COUNT_W'(BOUND)) begin
      n = COUNT_W'(BOUND);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/tmed_select.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Rank-based median pick: each active lane counts the active lanes that sort
// ahead of it (ties broken by lane index), and the lane of rank n/2 wins.
module tmed_select (
  input  wire tmed_pkg::median_req_t req_i,
  output tmed_pkg::sample_t          median_o
);
  import tmed_pkg::*;

  logic   [LANES-1:0] active;
  count_t             rank [LANES];
  count_t             target;
  sample_t            pick;

  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      active[j] = (COUNT_W'(j) < req_i.n);
    end
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      rank[i] = '0;
      for (int j = 0; j < LANES; j++) begin
        if (j != i && active[j]) begin
          if ((req_i.samples[j] < req_i.samples[i]) ||
              ((req_i.samples[j] == req_i.samples[i]) && (j < i))) begin
            rank[i] = rank[i] + COUNT_W'(1);
          end
        end
      end
    end
  end

  assign target = req_i.n >> 1;

  // Ranks of active lanes form a permutation, so exactly one lane matches.
  always_comb begin
    pick = '0;
    for (int i = 0; i < LANES; i++) begin
      if (active[i] && (rank[i] == target)) begin
        pick = pick | req_i.samples[i];
      end
    end
  end

  assign median_o = pick;

endmodule

`default_nettype wire

// ----- rtl/temporal_median_pixel.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Temporal median over up to eight aligned frames, one pixel position per transfer.
//
// Input stream (s_axis_*): tdata carries sample_0..sample_7, 8 bits each,
// sample_0 in the lowest byte. Output stream (m_axis_*): tdata carries the
// 8-bit median, the sample at index n/2 of the ascending order of the first
// n lanes, n being the frame count clamped to 1..8.
// Configuration: cfg_data_i is written to frame_count on cfg_valid_i; the
// channel is always ready. Write it only while no pixel is in flight.
// Path: an input transfer is captured in the input register; the rank compare
// and select then feed the result register, which drives m_axis_tvalid.
// Throughput: one pixel per cycle while the receiver accepts, set by the single-pass select logic
// between the two registers.
// Stall: when the receiver holds off, the result register keeps its value and
// the input register holds one more pixel; s_axis_tready drops only when both
// are full and m_axis_tready is low.
// Reset: both stages empty, frame_count back to 8.
module temporal_median_pixel (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 s_axis_tvalid,
  output logic                                s_axis_tready,
  // sample_0 [7:0], sample_1 [15:8], ... sample_7 [63:56]
  input  wire  [tmed_pkg::TDATA_IN_W-1:0]     s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  wire                                 m_axis_tready,
  // median_value [7:0]
  output logic [tmed_pkg::TDATA_OUT_W-1:0]    m_axis_tdata,
  input  wire                                 cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire  [tmed_pkg::COUNT_W-1:0]        cfg_data_i
);
  import tmed_pkg::*;

  count_t              frame_count_q;
  logic                in_valid_q;
  sample_t [LANES-1:0] in_samples_q;
  logic                out_valid_q;
  sample_t             out_data_q;
  logic                out_ready;
  logic                in_ready;
  median_req_t         req;
  sample_t             median;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q <= COUNT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      frame_count_q <= cfg_data_i;
    end
  end

  assign out_ready     = !out_valid_q || m_axis_tready;
  assign in_ready      = !in_valid_q || out_ready;
  assign s_axis_tready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && s_axis_tvalid) begin
      in_samples_q <= s_axis_tdata;
    end
  end

  assign req.samples = in_samples_q;
  assign req.n       = effective_count(frame_count_q);

  tmed_select u_select (
    .req_i    (req),
    .median_o (median)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && in_valid_q) begin
      out_data_q <= median;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

// ----- rtl/tmed_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tmed_checker (
  input wire                              clk_i,
  input wire                              rst_ni,
  input wire                              s_axis_tvalid,
  input wire                              s_axis_tready,
  input wire [tmed_pkg::TDATA_IN_W-1:0]   s_axis_tdata,
  input wire                              m_axis_tvalid,
  input wire                              m_axis_tready,
  input wire [tmed_pkg::TDATA_OUT_W-1:0]  m_axis_tdata
);
  import tmed_pkg::*;

  // A waiting input transfer keeps its data.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata))
    else $error("input changed while waiting");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // A result appearing in an empty output comes from an input transfer that passed the input and result registers.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result without matching input transfer");

  // Input backpressure only when the output side is stalled.
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled while output free");

endmodule

bind temporal_median_pixel tmed_checker u_tmed_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
